// File: rtl/tho_pkg.sv
package tho_pkg;

  localparam int CoordW = 31;
  localparam int CntW   = 11;

  localparam logic [1:0] RegTriCount = 2'd0;
  localparam logic [1:0] RegInvMode  = 2'd1;
  localparam logic [1:0] RegSrcH     = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LOAD,
    S_RD,
    S_WAIT,
    S_GET,
    S_ORI,
    S_CHK,
    S_MUL,
    S_ACC,
    S_DIVPRE,
    S_DIV,
    S_FIN,
    S_SAT,
    S_OUT
  } state_t;

endpackage

// File: rtl/tho_ram.sv
module tho_ram #(
  parameter int Width = 32,
  parameter int Depth = 3072
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/tin_height_offset_transform_core.sv
// tin_height_offset_transform_core
// Holds a table of triangles and offsets point heights by the surface found
// under each point.
// in_*  : input transactions. tuser = action (0 load, 1 transform). tdata packs
//         tri_index then the nine Q15.16 coordinates (A, B, C; x, y, z each).
//         A load writes three vertices to the slot, no output.
// out_* : one transaction per transform: x, y, z, hit.
// cfg_* : register writes (0 triangle_count, 1 inverse_mode, 2 source_height),
//         always ready; the user must write them only while the core is idle,
//         which the core itself does not enforce.
// Per slot visited: a read state, three vertex RAM reads, six orientation
// products on one shared multiplier, a check. The first slot holding the point
// adds the weight products, setup, a 128-step restoring divide, round and
// saturate; a miss over all slots returns the input point with hit clear.
// The block takes one transaction at a time.
// Reset clears the state and the configuration registers, not the vertex RAMs.
// When out_tready is low the result holds in the output register and
// in_tready stays low until it is taken.
module tin_height_offset_transform_core #(
  parameter int MaxTriangles = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic         in_tuser,   // action
  input  logic [295:0] in_tdata,   // tri_index[9:0], ax, ay, az, bx, by, bz, cx, cy, cz
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata,  // out_x, out_y, out_z, hit, zero pad
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [30:0]  cfg_data
);
  import tho_pkg::*;

  localparam int Depth = 3 * MaxTriangles;
  localparam int AW = $clog2(Depth);
  localparam int TW = $clog2(MaxTriangles + 1);

  state_t state_r, state_nxt;

  logic [CntW-1:0] tri_cnt_r;
  logic inv_r;
  logic signed [30:0] srch_r;

  logic [9:0] slot_r;
  logic [1:0] k_r;
  logic signed [30:0] ld_r [9];
  logic signed [30:0] px_r, py_r, pz_r;
  logic [TW-1:0] t_r;
  logic [AW-1:0] base_r;
  logic signed [31:0] vx_r [3];
  logic signed [31:0] vy_r [3];
  logic signed [31:0] vz_r [3];
  logic [2:0] oi_r;
  logic signed [63:0] o_r [3];
  logic signed [63:0] ptmp_r;
  logic signed [129:0] acc_r;
  logic neg_r;
  logic [127:0] num_r;
  logic [63:0] det_r, rem_r;
  logic [31:0] q_r;
  logic [7:0] dcnt_r;
  logic [30:0] ox_r, oy_r, oz_r;
  logic hit_r;

  // RAMs
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] wx, wy, wz, rx, ry, rz;
  logic [3:0] li;

  tho_ram #(.Width(32), .Depth(Depth)) u_rx (
    .clk, .we, .waddr, .wdata(wx), .raddr, .rdata(rx));
  tho_ram #(.Width(32), .Depth(Depth)) u_ry (
    .clk, .we, .waddr, .wdata(wy), .raddr, .rdata(ry));
  tho_ram #(.Width(32), .Depth(Depth)) u_rz (
    .clk, .we, .waddr, .wdata(wz), .raddr, .rdata(rz));

  logic [TW-1:0] n_lim;
  assign n_lim = (32'(tri_cnt_r) > MaxTriangles) ? TW'(MaxTriangles) : TW'(tri_cnt_r);

  assign we    = (state_r == S_LOAD) && ({1'b0, slot_r} < (MaxTriangles));
  assign waddr = AW'(slot_r * 3 + k_r);
  assign li    = 4'(3 * k_r);
  assign wx    = {ld_r[li][30], ld_r[li]};
  assign wy    = {ld_r[li + 4'd1][30], ld_r[li + 4'd1]};
  assign wz    = {ld_r[li + 4'd2][30], ld_r[li + 4'd2]};
  assign raddr = base_r + AW'(k_r);

  // shared multiplier: one signed 33x33 product per cycle
  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  logic [1:0] iu, iv;
  always_comb begin
    iu = (oi_r[2:1] == 2'd0) ? 2'd0 : (oi_r[2:1] == 2'd1) ? 2'd1 : 2'd2;
    iv = (iu == 2'd2) ? 2'd0 : iu + 2'd1;
    ma = '0;
    mb = '0;
    if (state_r == S_ORI) begin
      // even step: (Vx-Ux)*(Py-Uy); odd step: (Px-Ux)*(Vy-Uy)
      if (!oi_r[0]) begin
        ma = 33'(vx_r[iv]) - 33'(vx_r[iu]);
        mb = 33'(py_r) - 33'(vy_r[iu]);
      end else begin
        ma = 33'(px_r) - 33'(vx_r[iu]);
        mb = 33'(vy_r[iv]) - 33'(vy_r[iu]);
      end
    end else begin
      // weight limb times z: AB-P weights C, BC-P weights A, CA-P weights B
      ma = oi_r[0] ? 33'({1'b0, o_r[iu][63:32]}) : 33'({1'b0, o_r[iu][31:0]});
      mb = 33'(vz_r[(iu == 2'd0) ? 2'd2 : (iu == 2'd1) ? 2'd0 : 2'd1]);
    end
    mp = ma * mb;
  end

  logic [63:0] det_sum;
  assign det_sum = o_r[0] + o_r[1] + o_r[2];

  logic [64:0] rsh;
  assign rsh = {rem_r, num_r[127]};

  logic signed [32:0] hval;
  logic signed [33:0] resz;
  always_comb begin
    hval = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
    resz = inv_r ? 34'(pz_r) + 34'(hval) - 34'(srch_r)
                 : 34'(pz_r) - 34'(hval) + 34'(srch_r);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_tvalid) state_nxt = in_tuser ? S_RD : S_LOAD;
      S_LOAD:   if (k_r == 2'd2) state_nxt = S_IDLE;
      S_RD:     state_nxt = (t_r >= n_lim) ? S_OUT : S_WAIT;
      S_WAIT:   state_nxt = (k_r == 2'd2) ? S_GET : S_WAIT;
      S_GET:    state_nxt = S_ORI;
      S_ORI:    state_nxt = (oi_r == 3'd5) ? S_CHK : S_ORI;
      S_CHK:    state_nxt = (o_r[0] < 0 || o_r[1] < 0 || o_r[2] < 0 || det_sum == 0)
                            ? S_RD : S_MUL;
      S_MUL:    state_nxt = S_ACC;
      S_ACC:    state_nxt = (oi_r == 3'd5) ? S_DIVPRE : S_MUL;
      S_DIVPRE: state_nxt = S_DIV;
      S_DIV:    state_nxt = (dcnt_r == 8'd127) ? S_FIN : S_DIV;
      S_FIN:    state_nxt = S_SAT;
      S_SAT:    state_nxt = S_OUT;
      S_OUT:    if (out_tready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign cfg_ready  = 1'b1;
  assign out_tdata  = {2'b0, hit_r, oz_r, oy_r, ox_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      tri_cnt_r <= '0;
      inv_r     <= 1'b0;
      srch_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          RegTriCount: tri_cnt_r <= cfg_data[CntW-1:0];
          RegInvMode:  inv_r <= cfg_data[0];
          RegSrcH:     srch_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        k_r <= '0;
        slot_r <= in_tdata[9:0];
        for (int i = 0; i < 9; i++) ld_r[i] <= in_tdata[10 + 31*i +: 31];
        px_r <= in_tdata[40:10];
        py_r <= in_tdata[71:41];
        pz_r <= in_tdata[102:72];
        t_r <= '0;
        base_r <= '0;
        ox_r <= in_tdata[40:10];
        oy_r <= in_tdata[71:41];
        oz_r <= in_tdata[102:72];
        hit_r <= 1'b0;
      end
      S_LOAD: k_r <= k_r + 2'd1;
      S_RD: k_r <= '0;
      S_WAIT: begin
        if (k_r != 2'd0) begin
          vx_r[k_r-2'd1] <= rx; vy_r[k_r-2'd1] <= ry; vz_r[k_r-2'd1] <= rz;
        end
        k_r <= k_r + 2'd1;
      end
      S_GET: begin
        vx_r[2] <= rx; vy_r[2] <= ry; vz_r[2] <= rz;
        oi_r <= '0;
        k_r <= '0;
      end
      S_ORI: begin
        if (!oi_r[0]) ptmp_r <= mp[63:0];
        else o_r[oi_r[2:1]] <= ptmp_r - mp[63:0];
        oi_r <= oi_r + 3'd1;
      end
      S_CHK: begin
        t_r <= t_r + 1'b1;
        base_r <= base_r + AW'(3);
        det_r <= det_sum;
        acc_r <= '0;
        oi_r <= '0;
      end
      S_MUL: ptmp_r <= '0;
      S_ACC: begin
        if (oi_r[0]) acc_r <= acc_r + (130'(mp) <<< 32);
        else acc_r <= acc_r + 130'(mp);
        oi_r <= oi_r + 3'd1;
      end
      S_DIVPRE: begin
        neg_r <= acc_r[129];
        num_r <= acc_r[129] ? 128'(-acc_r) : acc_r[127:0];
        rem_r <= '0;
        q_r <= '0;
        dcnt_r <= '0;
      end
      S_DIV: begin
        if (rsh >= {1'b0, det_r}) begin
          rem_r <= 64'(rsh - {1'b0, det_r});
          q_r <= {q_r[30:0], 1'b1};
        end else begin
          rem_r <= rsh[63:0];
          q_r <= {q_r[30:0], 1'b0};
        end
        num_r <= {num_r[126:0], 1'b0};
        dcnt_r <= dcnt_r + 8'd1;
      end
      S_FIN: begin
        if (rem_r >= det_r - rem_r) q_r <= q_r + 32'd1;
      end
      S_SAT: begin
        if (resz > 34'sd1073741823) oz_r <= 31'h3FFFFFFF;
        else if (resz < -34'sd1073741824) oz_r <= 31'h40000000;
        else oz_r <= resz[30:0];
        hit_r <= 1'b1;
      end
      default: ;
    endcase
  end

  a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("out and in both open");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result dropped");
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> dcnt_r <= 8'd127) else $error("divide overrun");
endmodule

// File: verif/tb_tin_height_offset_transform_core.sv
`timescale 1ns / 100ps

module tb_tin_height_offset_transform_core;
  import tho_pkg::*;

  localparam logic [1:0] RegSpare = 2'd3;
  localparam logic ActLoad = 1'b0;
  localparam logic ActXform = 1'b1;
  localparam int NumTri = 1024;
  localparam longint ZHi = 64'sd1073741823;
  localparam longint ZLo = -64'sd1073741824;
  localparam int StallLimit = 40000;

  typedef struct packed {
    logic act;
    logic [9:0] idx;
    logic [8:0][30:0] crd;  // ax ay az bx by bz cx cy cz, crd[0] = ax
  } tin_item_t;

  typedef struct packed {
    logic hit;
    logic [30:0] z;
    logic [30:0] y;
    logic [30:0] x;
  } height_res_t;

  logic clk;
  logic rst_n;
  logic in_tvalid, in_tready, in_tuser;
  logic [295:0] in_tdata;
  logic out_tvalid, out_tready;
  logic [95:0] out_tdata;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [30:0] cfg_data;

  tin_height_offset_transform_core dut (.*);

  tin_item_t pend_q[$];
  height_res_t height_q[$];
  tin_item_t tri_shadow[NumTri];
  int errors = 0;

  // predictor state
  logic signed [30:0] vx_mem[3*NumTri];
  logic signed [30:0] vy_mem[3*NumTri];
  logic signed [30:0] vz_mem[3*NumTri];
  logic [10:0] p_count = '0;
  logic p_inv = 1'b0;
  logic signed [30:0] p_srch = '0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint orient(longint ux, longint uy, longint vx, longint vy,
                                    longint wx, longint wy);
    return (vx - ux) * (wy - uy) - (wx - ux) * (vy - uy);
  endfunction

  function automatic height_res_t surface_offset(tin_item_t it);
    height_res_t r;
    longint px, py, s1, s2, s3, ax, ay, bx, by, cx, cy;
    logic signed [127:0] acc, mag, det, q, rem, h, res, wa, wb, wc, za, zb, zc;
    int n;
    px = $signed(it.crd[0]);
    py = $signed(it.crd[1]);
    r.x = it.crd[0];
    r.y = it.crd[1];
    r.z = it.crd[2];
    r.hit = 1'b0;
    n = (p_count > NumTri) ? NumTri : int'(p_count);
    for (int t = 0; t < n; t++) begin
      ax = vx_mem[3*t]; ay = vy_mem[3*t];
      bx = vx_mem[3*t+1]; by = vy_mem[3*t+1];
      cx = vx_mem[3*t+2]; cy = vy_mem[3*t+2];
      s1 = orient(ax, ay, bx, by, px, py);
      if (s1 < 0) continue;
      s2 = orient(bx, by, cx, cy, px, py);
      if (s2 < 0) continue;
      s3 = orient(cx, cy, ax, ay, px, py);
      if (s3 < 0) continue;
      wa = s2; wb = s3; wc = s1;
      det = wa + wb + wc;
      if (det == 0) continue;
      za = vz_mem[3*t]; zb = vz_mem[3*t+1]; zc = vz_mem[3*t+2];
      acc = wa * za + wb * zb + wc * zc;
      mag = (acc < 0) ? -acc : acc;
      q = mag / det;
      rem = mag % det;
      if (2 * rem >= det) q = q + 1;
      h = (acc < 0) ? -q : q;
      za = $signed(it.crd[2]);
      zb = p_srch;
      res = p_inv ? za + h - zb : za - h + zb;
      if (res > ZHi) res = ZHi;
      if (res < ZLo) res = ZLo;
      r.z = res[30:0];
      r.hit = 1'b1;
      break;
    end
    return r;
  endfunction

  task automatic predict_item(tin_item_t it);
    if (it.act == ActLoad) begin
      for (int k = 0; k < 3; k++) begin
        vx_mem[3*it.idx+k] = it.crd[3*k];
        vy_mem[3*it.idx+k] = it.crd[3*k+1];
        vz_mem[3*it.idx+k] = it.crd[3*k+2];
      end
    end else begin
      height_q = {height_q, surface_offset(it)};
    end
  endtask

  // driver: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    logic nv;
    logic [295:0] pk;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      nv = in_tvalid;
      if (in_tvalid && in_tready) begin
        predict_item(pend_q[0]);
        void'(pend_q.pop_front());
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pend_q.size() > 0) begin
          nv = 1'b1;
          pk = '0;
          pk[9:0] = pend_q[0].idx;
          for (int k = 0; k < 9; k++) pk[10+31*k +: 31] = pend_q[0].crd[k];
          in_tdata <= pk;
          in_tuser <= pend_q[0].act;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
          end
        end
      end
      in_tvalid <= nv;
    end
  end

  // monitor and output stall pattern
  logic hold_req = 1'b0;
  logic hold_taken = 1'b0;
  int hold_cnt = 0;
  int cyc = 0;
  always @(posedge clk) begin
    height_res_t got, want;
    cyc++;
    if (out_tvalid && out_tready) begin
      got = out_tdata[93:0];
      if (height_q.size() == 0) begin
        $display("%0t: unexpected transaction %h", $time, got);
        errors++;
      end else begin
        want = height_q.pop_front();
        if (got.x !== want.x) begin
          $display("%0t: out_x exp %h got %h", $time, want.x, got.x);
          errors++;
        end
        if (got.y !== want.y) begin
          $display("%0t: out_y exp %h got %h", $time, want.y, got.y);
          errors++;
        end
        if (got.z !== want.z) begin
          $display("%0t: out_z exp %h got %h", $time, want.z, got.z);
          errors++;
        end
        if (got.hit !== want.hit) begin
          $display("%0t: hit exp %b got %b", $time, want.hit, got.hit);
          errors++;
        end
      end
    end
    if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_cnt = 600;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else if ((cyc / 256) % 2 == 0) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // watchdog
  int idle_cyc = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cyc = 0;
    else
      idle_cyc++;
    if (idle_cyc >= StallLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic cfg_write(logic [1:0] i, logic [30:0] d);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= i;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (i)
      RegTriCount: p_count = d[10:0];
      RegInvMode: p_inv = d[0];
      RegSrcH: p_srch = d;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (pend_q.size() > 0 || in_tvalid || height_q.size() > 0);
    repeat (20) @(negedge clk);
  endtask

  function automatic logic [30:0] rand_coord(int wide);
    logic [30:0] v;
    if (wide != 0) return 31'($urandom);
    v = 31'($urandom_range(0, 2097151)) - 31'd1048576;
    return v;
  endfunction

  // kind: 0 ccw, 1 degenerate, 2 cw; wide selects full coordinate range
  task automatic load_tri(int slot, int kind, int wide);
    tin_item_t it;
    longint o;
    logic [30:0] tx, ty;
    it.act = ActLoad;
    it.idx = slot[9:0];
    for (int k = 0; k < 9; k++) it.crd[k] = rand_coord(wide);
    if (kind == 1) begin
      it.crd[6] = it.crd[0];
      it.crd[7] = it.crd[1];
    end else begin
      o = orient($signed(it.crd[0]), $signed(it.crd[1]), $signed(it.crd[3]),
                 $signed(it.crd[4]), $signed(it.crd[6]), $signed(it.crd[7]));
      if ((kind == 0 && o < 0) || (kind == 2 && o > 0)) begin
        tx = it.crd[3]; ty = it.crd[4];
        it.crd[3] = it.crd[6]; it.crd[4] = it.crd[7];
        it.crd[6] = tx; it.crd[7] = ty;
      end
    end
    tri_shadow[slot] = it;
    pend_q = {pend_q, it};
  endtask

  task automatic push_point(logic [30:0] x, logic [30:0] y);
    tin_item_t it;
    it.act = ActXform;
    it.idx = 10'($urandom);
    for (int k = 0; k < 9; k++) it.crd[k] = 31'($urandom);
    it.crd[0] = x;
    it.crd[1] = y;
    pend_q = {pend_q, it};
  endtask

  task automatic point_in(int slot);
    longint ax, ay, bx, by, cx, cy;
    int u, v;
    tin_item_t s;
    s = tri_shadow[slot];
    ax = $signed(s.crd[0]); ay = $signed(s.crd[1]);
    bx = $signed(s.crd[3]); by = $signed(s.crd[4]);
    cx = $signed(s.crd[6]); cy = $signed(s.crd[7]);
    u = $urandom_range(0, 256);
    v = $urandom_range(0, 256 - u);
    push_point(31'(ax + ((bx - ax) * u + (cx - ax) * v) / 256),
               31'(ay + ((by - ay) * u + (cy - ay) * v) / 256));
  endtask

  task automatic random_phase(int ntri, int nitems);
    for (int i = 0; i < nitems; i++) begin
      case ($urandom_range(0, 9))
        0, 1: load_tri($urandom_range(0, ntri - 1), $urandom_range(0, 3) == 0 ?
                       $urandom_range(1, 2) : 0, $urandom_range(0, 3) == 0);
        2: push_point(31'($urandom), 31'($urandom));
        default: point_in($urandom_range(0, ntri - 1));
      endcase
    end
  endtask

  initial begin
    in_tvalid = 1'b0;
    in_tuser = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = RegTriCount;
    cfg_data = '0;
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty table: every point misses
    push_point(31'h3FFF_FFFF, 31'h4000_0000);
    push_point('0, '0);
    wait_drained();

    load_tri(0, 2, 0);
    load_tri(1, 1, 0);
    load_tri(2, 0, 0);
    load_tri(3, 0, 1);
    wait_drained();
    cfg_write(RegTriCount, 31'd4);
    cfg_write(RegSrcH, 31'h3FFF_FFFF);
    cfg_write(RegSpare, 31'h7FFF_FFFF);
    for (int t = 0; t < 4; t++) begin
      push_point(tri_shadow[t].crd[0], tri_shadow[t].crd[1]);
      push_point(tri_shadow[t].crd[3], tri_shadow[t].crd[4]);
      point_in(t);
    end
    push_point(31'h4000_0000, 31'h4000_0000);
    push_point(31'h3FFF_FFFF, 31'h3FFF_FFFF);
    wait_drained();
    cfg_write(RegInvMode, 31'd1);
    cfg_write(RegSrcH, 31'h4000_0000);
    point_in(2);
    point_in(3);
    push_point(tri_shadow[3].crd[6], tri_shadow[3].crd[7]);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      int ntri;
      ntri = $urandom_range(4, 16);
      for (int t = 4; t < ntri; t++) load_tri(t, 0, $urandom_range(0, 1));
      wait_drained();
      cfg_write(RegTriCount, 31'(ntri - $urandom_range(0, 3)));
      cfg_write(RegInvMode, 31'(ph % 2));
      cfg_write(RegSrcH, (ph == 2) ? 31'h4000_0000 : (ph == 5) ? 31'h3FFF_FFFF :
                rand_coord($urandom_range(0, 1)));
      if (ph == 3) hold_req = 1'b1;
      random_phase(ntri > 4 ? ntri : 4, 58);
      wait_drained();
    end

    repeat (200) @(negedge clk);

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: tin_height_offset_transform_core.f
rtl/tho_pkg.sv
rtl/tho_ram.sv
rtl/tin_height_offset_transform_core.sv
verif/tb_tin_height_offset_transform_core.sv
